>>> rtl/atacc_pkg.sv
// shared types, codes, constants and the sine table generator for the affine accumulator
package atacc_pkg;

	// operation codes carried in the func field
	typedef enum logic [1:0] {
		FN_ROTATE    = 2'd0,
		FN_REFLECT_X = 2'd1,
		FN_REFLECT_Y = 2'd2,
		FN_TRANSLATE = 2'd3
	} func_t;

	// quadrant of a reduced angle
	typedef enum logic [1:0] {
		QD_FIRST  = 2'd0,
		QD_SECOND = 2'd1,
		QD_THIRD  = 2'd2,
		QD_FOURTH = 2'd3
	} quad_t;

	typedef struct packed {
		func_t              func;
		logic signed [15:0] angle_deg;
		logic signed [31:0] axis_pos;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
	} req_word_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic               saturated;
	} rsp_word_t;

	// angle reduction: bias (92 full turns) makes the angle non-negative without changing
	// it mod 360, then floor(u / 360) = (u * DEG_RECIP) >> DEG_RECIP_SHIFT for every u
	// below 74000
	localparam int DEG_BIAS        = 33120;
	localparam int DEG_RECIP       = 46604;
	localparam int DEG_RECIP_SHIFT = 24;
	localparam int DEG_FULL        = 360;
	localparam int DEG_RIGHT       = 90;

	// width of the offset terms (twice a 32-bit position)
	localparam int OFS_W = 33;

	localparam real PI_VAL = 3.14159265358979323846;

	// sin of k whole degrees, rounded to frac fractional bits, ties upward
	function automatic int sin_deg_q(input int k, input int frac);
		real x;
		real v;
		x = $itor(k) * PI_VAL / 180.0;
		v = $sin(x) * (2.0 ** frac);
		return $rtoi($floor(v + 0.5));
	endfunction

endpackage

>>> rtl/atacc_front.sv
// front end: angle reduction, sine table lookup and transform coefficient build
module atacc_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  atacc_pkg::req_word_t req_word,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [4*(FRAC_BITS+2)+2*atacc_pkg::OFS_W-1:0] push_data
);

	localparam int CW = FRAC_BITS + 2;
	localparam int TW = FRAC_BITS + 1;
	localparam int OW = atacc_pkg::OFS_W;
	localparam logic signed [CW-1:0] ONE_C = {2'b01, {FRAC_BITS{1'b0}}};

	// sin of 0..90 degrees, non-negative
	logic [TW-1:0] sin_tab [0:90];

	for (genvar k = 0; k <= 90; k++) begin : g_tab
		localparam logic [TW-1:0] TAB_V = TW'(atacc_pkg::sin_deg_q(k, FRAC_BITS));
		assign sin_tab[k] = TAB_V;
	end

	// stage 1: biased angle and its quotient by 360
	logic signed [16:0] ang_x;
	logic [16:0]        ang_u;
	logic [32:0]        quo_prod;
	logic               adv;

	logic                 valid_s1;
	atacc_pkg::func_t     func_s1;
	logic [16:0]          ang_u_s1;
	logic [7:0]           quo_s1;
	logic signed [31:0]   axis_s1;
	logic signed [31:0]   shx_s1;
	logic signed [31:0]   shy_s1;

	assign ang_x    = 17'(req_word.angle_deg);
	assign ang_u    = unsigned'(ang_x + 17'(atacc_pkg::DEG_BIAS));
	assign quo_prod = 33'(ang_u) * 33'(atacc_pkg::DEG_RECIP);

	assign adv       = !valid_s1 || push_ready;
	assign req_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req_valid) begin
			func_s1  <= req_word.func;
			ang_u_s1 <= ang_u;
			quo_s1   <= quo_prod[atacc_pkg::DEG_RECIP_SHIFT +: 8];
			axis_s1  <= req_word.axis_pos;
			shx_s1   <= req_word.shift_x;
			shy_s1   <= req_word.shift_y;
		end
	end

	// stage 2: remainder, quadrant, table reads, coefficients
	logic [16:0]          rem_full;
	logic [8:0]           rem;
	atacc_pkg::quad_t     quad;
	logic [6:0]           red;
	logic signed [CW-1:0] sin_p;
	logic signed [CW-1:0] cos_p;
	logic signed [CW-1:0] sin_v;
	logic signed [CW-1:0] cos_v;
	logic signed [CW-1:0] coef_a;
	logic signed [CW-1:0] coef_b;
	logic signed [CW-1:0] coef_d;
	logic signed [CW-1:0] coef_e;
	logic signed [OW-1:0] ofs_x;
	logic signed [OW-1:0] ofs_y;

	assign rem_full = ang_u_s1 - 17'(quo_s1) * 17'(atacc_pkg::DEG_FULL);
	assign rem      = rem_full[8:0];

	always_comb begin
		if (rem >= 9'(3 * atacc_pkg::DEG_RIGHT)) begin
			quad = atacc_pkg::QD_FOURTH;
			red  = 7'(rem - 9'(3 * atacc_pkg::DEG_RIGHT));
		end else if (rem >= 9'(2 * atacc_pkg::DEG_RIGHT)) begin
			quad = atacc_pkg::QD_THIRD;
			red  = 7'(rem - 9'(2 * atacc_pkg::DEG_RIGHT));
		end else if (rem >= 9'(atacc_pkg::DEG_RIGHT)) begin
			quad = atacc_pkg::QD_SECOND;
			red  = 7'(rem - 9'(atacc_pkg::DEG_RIGHT));
		end else begin
			quad = atacc_pkg::QD_FIRST;
			red  = 7'(rem);
		end
	end

	assign sin_p = signed'({1'b0, sin_tab[red]});
	assign cos_p = signed'({1'b0, sin_tab[7'(atacc_pkg::DEG_RIGHT) - red]});

	always_comb begin
		case (quad)
			atacc_pkg::QD_FIRST: begin
				sin_v = sin_p;
				cos_v = cos_p;
			end
			atacc_pkg::QD_SECOND: begin
				sin_v = cos_p;
				cos_v = -sin_p;
			end
			atacc_pkg::QD_THIRD: begin
				sin_v = -sin_p;
				cos_v = -cos_p;
			end
			default: begin
				sin_v = -cos_p;
				cos_v = sin_p;
			end
		endcase
	end

	always_comb begin
		coef_a = ONE_C;
		coef_b = '0;
		coef_d = '0;
		coef_e = ONE_C;
		ofs_x  = '0;
		ofs_y  = '0;
		case (func_s1)
			atacc_pkg::FN_ROTATE: begin
				coef_a = cos_v;
				coef_b = -sin_v;
				coef_d = sin_v;
				coef_e = cos_v;
			end
			atacc_pkg::FN_REFLECT_X: begin
				coef_a = -ONE_C;
				ofs_x  = signed'({axis_s1, 1'b0});
			end
			atacc_pkg::FN_REFLECT_Y: begin
				coef_e = -ONE_C;
				ofs_y  = signed'({axis_s1, 1'b0});
			end
			default: begin
				ofs_x = OW'(shx_s1);
				ofs_y = OW'(shy_s1);
			end
		endcase
	end

	assign push_valid = valid_s1;
	assign push_data  = {coef_a, coef_b, coef_d, coef_e, ofs_x, ofs_y};

endmodule

>>> rtl/atacc_queue.sv
// two-entry queue between the front end and the matrix update
module atacc_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_fire) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 2'd1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/atacc_back.sv
// back end: matrix state, left multiply by the transform, rounding, saturation, result register
module atacc_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [4*(FRAC_BITS+2)+2*atacc_pkg::OFS_W-1:0] pop_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output atacc_pkg::rsp_word_t rsp_word
);

	localparam int CW = FRAC_BITS + 2;
	localparam int OW = atacc_pkg::OFS_W;
	localparam int EW = 4 * CW + 2 * OW;
	localparam int PW = CW + 32;
	localparam int RW = PW - FRAC_BITS;
	localparam int SW = RW + 2;
	localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SAT_HI = {{(SW - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW - 31){1'b1}}, 31'd0};
	localparam logic signed [31:0]   ONE_Q  = 32'(1) <<< FRAC_BITS;

	// product rounded to nearest, ties upward
	function automatic logic signed [RW-1:0] rnd_prod(input logic signed [CW-1:0] c,
			input logic signed [31:0] v);
		logic signed [PW-1:0] p;
		p = PW'(c) * PW'(v);
		p = p + HALF_P;
		return RW'(p >>> FRAC_BITS);
	endfunction

	logic signed [CW-1:0] coef_a;
	logic signed [CW-1:0] coef_b;
	logic signed [CW-1:0] coef_d;
	logic signed [CW-1:0] coef_e;
	logic signed [OW-1:0] ofs_x;
	logic signed [OW-1:0] ofs_y;

	assign coef_a = pop_data[EW-1 -: CW];
	assign coef_b = pop_data[EW-CW-1 -: CW];
	assign coef_d = pop_data[EW-2*CW-1 -: CW];
	assign coef_e = pop_data[EW-3*CW-1 -: CW];
	assign ofs_x  = pop_data[2*OW-1 -: OW];
	assign ofs_y  = pop_data[OW-1:0];

	// entries in order m00 m01 m02 m10 m11 m12
	logic signed [31:0] m_q    [6];
	logic signed [31:0] m_nxt  [6];
	logic               clip   [6];
	logic               rsp_valid_q;
	atacc_pkg::rsp_word_t rsp_q;
	logic               take;

	for (genvar j = 0; j < 3; j++) begin : g_col
		logic signed [OW-1:0] t0;
		logic signed [OW-1:0] t1;
		logic signed [SW-1:0] sum0;
		logic signed [SW-1:0] sum1;

		assign t0 = (j == 2) ? ofs_x : '0;
		assign t1 = (j == 2) ? ofs_y : '0;

		assign sum0 = SW'(rnd_prod(coef_a, m_q[j])) + SW'(rnd_prod(coef_b, m_q[3 + j]))
			+ SW'(t0);
		assign sum1 = SW'(rnd_prod(coef_d, m_q[j])) + SW'(rnd_prod(coef_e, m_q[3 + j]))
			+ SW'(t1);

		always_comb begin
			clip[j]      = 1'b1;
			clip[3 + j]  = 1'b1;
			if (sum0 > SAT_HI) begin
				m_nxt[j] = SAT_HI[31:0];
			end else if (sum0 < SAT_LO) begin
				m_nxt[j] = SAT_LO[31:0];
			end else begin
				m_nxt[j] = sum0[31:0];
				clip[j]  = 1'b0;
			end
			if (sum1 > SAT_HI) begin
				m_nxt[3 + j] = SAT_HI[31:0];
			end else if (sum1 < SAT_LO) begin
				m_nxt[3 + j] = SAT_LO[31:0];
			end else begin
				m_nxt[3 + j] = sum1[31:0];
				clip[3 + j]  = 1'b0;
			end
		end
	end

	assign pop_ready = !rsp_valid_q || rsp_ready;
	assign take      = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q[0]      <= ONE_Q;
			m_q[1]      <= '0;
			m_q[2]      <= '0;
			m_q[3]      <= '0;
			m_q[4]      <= ONE_Q;
			m_q[5]      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				for (int i = 0; i < 6; i++) begin
					m_q[i] <= m_nxt[i];
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.m00       <= m_nxt[0];
			rsp_q.m01       <= m_nxt[1];
			rsp_q.m02       <= m_nxt[2];
			rsp_q.m10       <= m_nxt[3];
			rsp_q.m11       <= m_nxt[4];
			rsp_q.m12       <= m_nxt[5];
			rsp_q.saturated <= clip[0] | clip[1] | clip[2] | clip[3] | clip[4] | clip[5];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule

>>> rtl/affine_transform_accumulator.sv
// top level of the 2d affine transform accumulator
//
// keeps the top two rows of a 2d affine matrix (identity after reset) and left-multiplies it
// by one elementary transform per request word: rotation by whole degrees counterclockwise,
// reflection about x=p or y=p, or translation by (x,y); entries are signed fixed point with
// FRAC_BITS fraction bits, products round to nearest with ties upward, sums clip to 32 bits
// and the saturated bit marks any clipped entry; every request word yields one response word
// holding the six updated entries. the block takes one request word per cycle and gives one
// response word per cycle when the response side keeps ready high; a word moves in order
// through the front stage register (the angle and its quotient), the queue, into which the
// coefficient build is written, and the result register, which the matrix update loads; a
// stall can hold it at any of these. the rate is set by the matrix update, whose twelve
// multiplies and sums close the state feedback loop with no register inside it.
module affine_transform_accumulator #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_ready,
	input  atacc_pkg::req_word_t req_word,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output atacc_pkg::rsp_word_t rsp_word
);

	// queue entry: four coefficients then the two offsets
	localparam int EW = 4 * (FRAC_BITS + 2) + 2 * atacc_pkg::OFS_W;

	logic          fq_valid;
	logic          fq_ready;
	logic [EW-1:0] fq_data;
	logic          qb_valid;
	logic          qb_ready;
	logic [EW-1:0] qb_data;

	// front end: mod 360, quadrant fold, sine table, transform coefficients
	atacc_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_word   (req_word),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data)
	);

	// decouples the front end from the update so either side can stall
	atacc_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	// matrix state and result register
	atacc_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (qb_valid),
		.pop_ready (qb_ready),
		.pop_data  (qb_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

endmodule
